### src/gf2rs_pkg.sv
// ----------------------------------------------------------------------------
// gf2rs_pkg: shared types and constants for the GF(2) row sparsifier
// Payload structs, sequencer state codes, pass codes, fixed field widths and
// the popcount helper used by the evaluation datapath.
// ----------------------------------------------------------------------------
package gf2rs_pkg;

    localparam int unsigned ROW_W       = 64;
    localparam int unsigned ROW_INDEX_W = 6;
    localparam int unsigned SAVED_W     = 13;
    localparam int unsigned CCOUNT_W    = 7;
    localparam int unsigned POP_W       = 7;
    localparam int unsigned LIMIT_W     = 14;

    localparam logic [LIMIT_W-1:0]  FOUR_ROW_LIMIT     = 14'd100;
    localparam logic [LIMIT_W-1:0]  THREE_ROW_LIMIT    = 14'd500;
    localparam logic [LIMIT_W-1:0]  TWO_ROW_LIMIT      = 14'd10000;
    localparam logic [SAVED_W-1:0]  SAVED_MAX          = 13'd8191;
    localparam logic [CCOUNT_W-1:0] COLUMN_COUNT_RESET = 7'd64;

    typedef struct packed {
        logic [ROW_W-1:0] row_bits;
        logic             last_row;
    } in_item_t;

    typedef struct packed {
        logic [ROW_W-1:0]       out_row_bits;
        logic [ROW_INDEX_W-1:0] row_index;
        logic [SAVED_W-1:0]     ones_removed;
        logic                   last_out;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CHECK,
        ST_STEP,
        ST_ISSUE,
        ST_ACC,
        ST_EVAL,
        ST_UPD,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    // Number of rows combined per try: four, three or two
    typedef enum logic [1:0] {
        PASS_FOUR,
        PASS_THREE,
        PASS_TWO
    } pass_t;

    // Innermost loop level used by a pass
    function automatic logic [1:0] last_level(input pass_t pass);
        logic [1:0] lv;
        unique case (pass)
            PASS_FOUR:  lv = 2'd3;
            PASS_THREE: lv = 2'd2;
            PASS_TWO:   lv = 2'd1;
            default:    lv = 2'd1;
        endcase
        return lv;
    endfunction

    // Parallel bit count, six folding steps
    function automatic logic [POP_W-1:0] popcount(input logic [ROW_W-1:0] v);
        logic [ROW_W-1:0] x;
        x = v - ((v >> 1) & 64'h5555_5555_5555_5555);
        x = (x & 64'h3333_3333_3333_3333) + ((x >> 2) & 64'h3333_3333_3333_3333);
        x = (x + (x >> 4)) & 64'h0f0f_0f0f_0f0f_0f0f;
        x = x + (x >> 8);
        x = x + (x >> 16);
        x = x + (x >> 32);
        return x[POP_W-1:0];
    endfunction

endpackage

### src/gf2_row_sparsifier.sv
// ----------------------------------------------------------------------------
// gf2_row_sparsifier: greedy one-bit reduction of a GF(2) matrix
// Loads rows into an internal store, runs XOR replacement passes over row
// combinations, then streams the sparsified rows with the total bits saved.
// ----------------------------------------------------------------------------
// Rows load at one per cycle into a single-port row memory (rows past
// MAX_ROWS are dropped). The transaction marked last_row starts the passes and
// input stays stalled until the final row is handed to the output register.
// With m rows held, a pass visits all m^d index tuples of its depth d (4, 3 or
// 2 rows) in order: a tuple with a repeated index is only checked and stepped
// past, while for a distinct one every row is fetched through the one memory
// read port, and the target row and the candidate are judged by the one shared
// popcount unit. The four-row pass runs when m < 100, the three-row pass when
// m < 500 and the two-row pass when m < 10000. Output then reads each row from
// the memory and loads it into the output register, stalling on out_ready.
module gf2_row_sparsifier #(
    parameter int unsigned MAX_ROWS = 64,
    parameter int unsigned MAX_COLS = 64
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  gf2rs_pkg::in_item_t                     in_data,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output gf2rs_pkg::out_item_t                    out_data,
    input  logic                                    cfg_wr_en,
    input  logic [gf2rs_pkg::CCOUNT_W-1:0]          cfg_wr_data
);

    localparam int unsigned IDX_W = $clog2(MAX_ROWS);
    localparam int unsigned CNT_W = $clog2(MAX_ROWS + 1);

    // Row memory
    logic [MAX_COLS-1:0] row_mem [MAX_ROWS];
    logic [MAX_COLS-1:0] rd_data_reg;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [MAX_COLS-1:0] wr_data;

    // Control state
    gf2rs_pkg::state_t                  state_reg, state_next;
    gf2rs_pkg::pass_t                   pass_reg, pass_next;
    logic [CNT_W-1:0]                   rows_loaded_reg, rows_loaded_next;
    logic [gf2rs_pkg::SAVED_W-1:0]      saved_total_reg, saved_total_next;
    logic [IDX_W-1:0]                   ix_reg [4];
    logic [IDX_W-1:0]                   ix_next [4];
    logic [1:0]                         rk_reg, rk_next;
    logic [IDX_W-1:0]                   k_reg, k_next;
    logic                               out_valid_reg, out_valid_next;
    logic [gf2rs_pkg::CCOUNT_W-1:0]     column_count_reg;

    // Datapath
    logic [MAX_COLS-1:0]                target_reg, target_next;
    logic [MAX_COLS-1:0]                acc_reg, acc_next;
    logic [MAX_COLS-1:0]                cand_reg, cand_next;
    logic [gf2rs_pkg::POP_W-1:0]        tgt_ones_reg, tgt_ones_next;
    logic [gf2rs_pkg::POP_W-1:0]        cand_ones_reg, cand_ones_next;
    gf2rs_pkg::out_item_t               out_data_reg, out_data_next;

    logic [MAX_COLS-1:0]                col_mask;
    logic [MAX_COLS-1:0]                in_row_masked;
    logic [MAX_COLS-1:0]                pop_in;
    logic [gf2rs_pkg::POP_W-1:0]        pop_out;
    logic [IDX_W-1:0]                   m_last;
    logic [1:0]                         lvl_last;
    logic [IDX_W-1:0]                   step_ix [4];
    logic                               step_carry;
    logic                               combo_ok;
    logic [gf2rs_pkg::LIMIT_W-1:0]      lim_m;
    gf2rs_pkg::pass_t                   pass_sel;
    logic                               pass_go;
    logic                               out_free;
    logic [gf2rs_pkg::SAVED_W:0]        saved_sum;

    assign in_row_masked = in_data.row_bits[MAX_COLS-1:0] & col_mask;
    assign m_last        = IDX_W'(rows_loaded_reg - CNT_W'(1));
    assign lvl_last      = gf2rs_pkg::last_level(pass_reg);
    assign out_free      = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;

    // Shared popcount: fetched target row in ACC, candidate in EVAL
    assign pop_in  = (state_reg == gf2rs_pkg::ST_ACC) ? rd_data_reg : (target_reg ^ acc_reg);
    assign pop_out = gf2rs_pkg::popcount(gf2rs_pkg::ROW_W'(pop_in));

    assign saved_sum = {1'b0, saved_total_reg}
                     + (gf2rs_pkg::SAVED_W + 1)'(tgt_ones_reg - cand_ones_reg);

    always_comb
    begin
        for (int s = 0; s < MAX_COLS; s++)
        begin
            col_mask[s] = (gf2rs_pkg::CCOUNT_W'(s) < column_count_reg);
        end
    end

    // Odometer advance over the levels of the current pass
    always_comb
    begin
        step_carry = 1'b1;
        for (int lv = 3; lv >= 0; lv--)
        begin
            step_ix[lv] = ix_reg[lv];
            if (step_carry && (2'(lv) <= lvl_last))
            begin
                if (ix_reg[lv] == m_last)
                begin
                    step_ix[lv] = '0;
                end
                else
                begin
                    step_ix[lv] = ix_reg[lv] + 1'b1;
                    step_carry  = 1'b0;
                end
            end
        end
    end

    // All rows of the tuple must differ
    assign combo_ok = (ix_reg[1] != ix_reg[0])
                   && ((lvl_last < 2'd2)
                       || ((ix_reg[2] != ix_reg[0]) && (ix_reg[2] != ix_reg[1])))
                   && ((lvl_last < 2'd3)
                       || ((ix_reg[3] != ix_reg[0]) && (ix_reg[3] != ix_reg[1])
                           && (ix_reg[3] != ix_reg[2])));

    // Pick the next pass, from load or from the end of the current one
    always_comb
    begin
        lim_m    = gf2rs_pkg::LIMIT_W'(rows_loaded_next);
        pass_go  = 1'b1;
        pass_sel = gf2rs_pkg::PASS_TWO;
        if ((state_reg == gf2rs_pkg::ST_LOAD) && (lim_m < gf2rs_pkg::FOUR_ROW_LIMIT))
        begin
            pass_sel = gf2rs_pkg::PASS_FOUR;
        end
        else if (((state_reg == gf2rs_pkg::ST_LOAD) || (pass_reg == gf2rs_pkg::PASS_FOUR))
                 && (lim_m < gf2rs_pkg::THREE_ROW_LIMIT))
        begin
            pass_sel = gf2rs_pkg::PASS_THREE;
        end
        else if (((state_reg == gf2rs_pkg::ST_LOAD) || (pass_reg != gf2rs_pkg::PASS_TWO))
                 && (lim_m < gf2rs_pkg::TWO_ROW_LIMIT))
        begin
            pass_sel = gf2rs_pkg::PASS_TWO;
        end
        else
        begin
            pass_go = 1'b0;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        pass_next        = pass_reg;
        rows_loaded_next = rows_loaded_reg;
        saved_total_next = saved_total_reg;
        ix_next          = ix_reg;
        rk_next          = rk_reg;
        k_next           = k_reg;
        target_next      = target_reg;
        acc_next         = acc_reg;
        cand_next        = cand_reg;
        tgt_ones_next    = tgt_ones_reg;
        cand_ones_next   = cand_ones_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_data_next    = out_data_reg;
        in_ready         = 1'b0;
        rd_en            = 1'b0;
        rd_addr          = '0;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = '0;

        unique case (state_reg)
            gf2rs_pkg::ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    // Drop rows once the store is full
                    if (rows_loaded_reg < CNT_W'(MAX_ROWS))
                    begin
                        wr_en            = 1'b1;
                        wr_addr          = rows_loaded_reg[IDX_W-1:0];
                        wr_data          = in_row_masked;
                        rows_loaded_next = rows_loaded_reg + 1'b1;
                    end
                    if (in_data.last_row)
                    begin
                        saved_total_next = '0;
                        if (pass_go)
                        begin
                            pass_next  = pass_sel;
                            ix_next    = '{default: '0};
                            state_next = gf2rs_pkg::ST_CHECK;
                        end
                        else
                        begin
                            k_next     = '0;
                            state_next = gf2rs_pkg::ST_EMIT_RD;
                        end
                    end
                end
            end

            gf2rs_pkg::ST_CHECK:
            begin
                if (combo_ok)
                begin
                    rk_next    = '0;
                    state_next = gf2rs_pkg::ST_ISSUE;
                end
                else
                begin
                    state_next = gf2rs_pkg::ST_STEP;
                end
            end

            gf2rs_pkg::ST_STEP:
            begin
                if (step_carry)
                begin
                    if (pass_go)
                    begin
                        pass_next  = pass_sel;
                        ix_next    = '{default: '0};
                        state_next = gf2rs_pkg::ST_CHECK;
                    end
                    else
                    begin
                        k_next     = '0;
                        state_next = gf2rs_pkg::ST_EMIT_RD;
                    end
                end
                else
                begin
                    ix_next    = step_ix;
                    state_next = gf2rs_pkg::ST_CHECK;
                end
            end

            gf2rs_pkg::ST_ISSUE:
            begin
                rd_en      = 1'b1;
                rd_addr    = ix_reg[rk_reg];
                state_next = gf2rs_pkg::ST_ACC;
            end

            gf2rs_pkg::ST_ACC:
            begin
                if (rk_reg == 2'd0)
                begin
                    target_next   = rd_data_reg;
                    tgt_ones_next = pop_out;
                    acc_next      = '0;
                end
                else
                begin
                    acc_next = acc_reg ^ rd_data_reg;
                end
                if (rk_reg == lvl_last)
                begin
                    state_next = gf2rs_pkg::ST_EVAL;
                end
                else
                begin
                    rk_next    = rk_reg + 1'b1;
                    state_next = gf2rs_pkg::ST_ISSUE;
                end
            end

            gf2rs_pkg::ST_EVAL:
            begin
                cand_next      = target_reg ^ acc_reg;
                cand_ones_next = pop_out;
                state_next     = gf2rs_pkg::ST_UPD;
            end

            gf2rs_pkg::ST_UPD:
            begin
                // Write through so later tuples see the replaced row
                if (cand_ones_reg < tgt_ones_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = ix_reg[0];
                    wr_data = cand_reg;
                    if (saved_sum > {1'b0, gf2rs_pkg::SAVED_MAX})
                    begin
                        saved_total_next = gf2rs_pkg::SAVED_MAX;
                    end
                    else
                    begin
                        saved_total_next = saved_sum[gf2rs_pkg::SAVED_W-1:0];
                    end
                end
                state_next = gf2rs_pkg::ST_STEP;
            end

            gf2rs_pkg::ST_EMIT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = k_reg;
                state_next = gf2rs_pkg::ST_EMIT_LD;
            end

            gf2rs_pkg::ST_EMIT_LD:
            begin
                // Hold the fetched row until the output register frees up
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.out_row_bits  = gf2rs_pkg::ROW_W'(rd_data_reg);
                    out_data_next.row_index     = gf2rs_pkg::ROW_INDEX_W'(k_reg);
                    out_data_next.ones_removed  = saved_total_reg;
                    out_data_next.last_out      = (k_reg == m_last);
                    if (k_reg == m_last)
                    begin
                        rows_loaded_next = '0;
                        state_next       = gf2rs_pkg::ST_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = gf2rs_pkg::ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = gf2rs_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= row_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= gf2rs_pkg::ST_LOAD;
            pass_reg         <= gf2rs_pkg::PASS_FOUR;
            rows_loaded_reg  <= '0;
            saved_total_reg  <= '0;
            ix_reg           <= '{default: '0};
            rk_reg           <= '0;
            k_reg            <= '0;
            out_valid_reg    <= 1'b0;
            column_count_reg <= gf2rs_pkg::COLUMN_COUNT_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            pass_reg         <= pass_next;
            rows_loaded_reg  <= rows_loaded_next;
            saved_total_reg  <= saved_total_next;
            ix_reg           <= ix_next;
            rk_reg           <= rk_next;
            k_reg            <= k_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_wr_en)
            begin
                column_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg    <= target_next;
        acc_reg       <= acc_next;
        cand_reg      <= cand_next;
        tgt_ones_reg  <= tgt_ones_next;
        cand_ones_reg <= cand_ones_next;
        out_data_reg  <= out_data_next;
    end

`ifndef NO_ASSERTIONS
    a_rows_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        rows_loaded_reg <= CNT_W'(MAX_ROWS))
        else $error("row count exceeds store depth");

    a_distinct_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gf2rs_pkg::ST_ISSUE) |-> (ix_reg[0] != ix_reg[1]))
        else $error("target row fetched as its own partner");

    a_saved_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gf2rs_pkg::ST_UPD) |=> (saved_total_reg >= $past(saved_total_reg)))
        else $error("saved total decreased during a pass");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == gf2rs_pkg::ST_EMIT_LD) && out_free && (k_reg == m_last))
        |=> ((state_reg == gf2rs_pkg::ST_LOAD) && (rows_loaded_reg == '0)
             && out_valid_reg && out_data_reg.last_out))
        else $error("run did not close after its final row");
`endif

endmodule

### verif/gf2_row_sparsifier_tb.sv
// ----------------------------------------------------------------------------
// gf2_row_sparsifier_tb: self-checking bench for the GF(2) row sparsifier
// Feeds matrices row by row through the valid/ready input, rebuilds the greedy
// XOR reduction in a behavioral predictor, and compares every streamed row,
// index, saved-bit total and end flag against it. Random idling on both sides,
// output back-pressure and several column_count settings are exercised.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module gf2_row_sparsifier_tb;

    localparam int unsigned STORE_DEPTH = 64;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned LONG_HOLD = 1000;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    gf2rs_pkg::in_item_t            in_data = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    gf2rs_pkg::out_item_t           out_data;
    logic                           cfg_wr_en = 1'b0;
    logic [gf2rs_pkg::CCOUNT_W-1:0] cfg_wr_data = '0;

    // Predictor state
    logic [gf2rs_pkg::CCOUNT_W-1:0] col_count = gf2rs_pkg::COLUMN_COUNT_RESET;
    logic [gf2rs_pkg::ROW_W-1:0]    held_rows [STORE_DEPTH];
    int unsigned                    held_count = 0;
    int unsigned                    saved_acc = 0;
    gf2rs_pkg::out_item_t           sparse_rows_q [$];
    gf2rs_pkg::out_item_t           next_want;

    int unsigned         fail_count = 0;
    int unsigned         cycle_count = 0;
    bit                  tx_gaps_on = 1'b1;
    bit                  rx_stall_on = 1'b1;
    int unsigned         rx_hold_len = 0;

    gf2_row_sparsifier u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 clk = ~clk;

    function automatic logic [gf2rs_pkg::ROW_W-1:0] column_mask(
        input logic [gf2rs_pkg::CCOUNT_W-1:0] cc);
        if (cc >= gf2rs_pkg::ROW_W)
            return '1;
        return (64'd1 << cc) - 64'd1;
    endfunction

    // Replace the target row by its XOR with the combination if that drops ones
    function automatic void try_fold(input int unsigned t,
                                     input logic [gf2rs_pkg::ROW_W-1:0] combo);
        int unsigned                 cur_ones;
        int unsigned                 new_ones;
        logic [gf2rs_pkg::ROW_W-1:0] cand;
        cand     = held_rows[t] ^ combo;
        cur_ones = $countones(held_rows[t]);
        new_ones = $countones(cand);
        if (new_ones < cur_ones)
        begin
            saved_acc = saved_acc + cur_ones - new_ones;
            if (saved_acc > gf2rs_pkg::SAVED_MAX)
                saved_acc = gf2rs_pkg::SAVED_MAX;
            held_rows[t] = cand;
        end
    endfunction

    function automatic void greedy_reduce();
        int unsigned m;
        int unsigned a;
        int unsigned b;
        int unsigned c;
        int unsigned d;
        m = held_count;
        saved_acc = 0;
        if (m < gf2rs_pkg::FOUR_ROW_LIMIT)
        begin
            for (a = 0; a < m; a++)
                for (b = 0; b < m; b++)
                begin
                    if (b == a)
                        continue;
                    for (c = 0; c < m; c++)
                    begin
                        if (c == a || c == b)
                            continue;
                        for (d = 0; d < m; d++)
                        begin
                            if (d == a || d == b || d == c)
                                continue;
                            try_fold(a, held_rows[b] ^ held_rows[c] ^ held_rows[d]);
                        end
                    end
                end
        end
        if (m < gf2rs_pkg::THREE_ROW_LIMIT)
        begin
            for (a = 0; a < m; a++)
                for (b = 0; b < m; b++)
                begin
                    if (b == a)
                        continue;
                    for (c = 0; c < m; c++)
                    begin
                        if (c == a || c == b)
                            continue;
                        try_fold(a, held_rows[b] ^ held_rows[c]);
                    end
                end
        end
        if (m < gf2rs_pkg::TWO_ROW_LIMIT)
        begin
            for (a = 0; a < m; a++)
                for (b = 0; b < m; b++)
                begin
                    if (b == a)
                        continue;
                    try_fold(a, held_rows[b]);
                end
        end
    endfunction

    // Store an accepted row; on the last row reduce and queue the output rows
    function automatic void take_row(input logic [gf2rs_pkg::ROW_W-1:0] bits,
                                     input logic last);
        gf2rs_pkg::out_item_t r;
        int unsigned          k;
        if (held_count < STORE_DEPTH)
        begin
            held_rows[held_count] = bits & column_mask(col_count);
            held_count++;
        end
        if (last)
        begin
            greedy_reduce();
            for (k = 0; k < held_count; k++)
            begin
                r.out_row_bits = held_rows[k];
                r.row_index    = k[gf2rs_pkg::ROW_INDEX_W-1:0];
                r.ones_removed = saved_acc[gf2rs_pkg::SAVED_W-1:0];
                r.last_out     = (k + 1 == held_count);
                sparse_rows_q.push_back(r);
            end
            held_count = 0;
        end
    endfunction

    task automatic send_row(input logic [gf2rs_pkg::ROW_W-1:0] bits, input logic last);
        int unsigned gap;
        gap = (tx_gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid         <= 1'b1;
        in_data.row_bits <= bits;
        in_data.last_row <= last;
        do
            @(posedge clk);
        while (!in_ready);
        take_row(bits, last);
    endtask

    task automatic send_matrix(input int unsigned rows);
        logic [gf2rs_pkg::ROW_W-1:0] prev [$];
        logic [gf2rs_pkg::ROW_W-1:0] bits;
        int unsigned                 r;
        for (r = 0; r < rows; r++)
        begin
            bits = {$urandom, $urandom};
            case ($urandom_range(0, 7))
                2:
                begin
                    bits = '0;
                    repeat ($urandom_range(1, 4))
                        bits[$urandom_range(0, gf2rs_pkg::ROW_W - 1)] = 1'b1;
                end
                3:
                    if (prev.size() > 0)
                        bits = prev[$urandom_range(0, prev.size() - 1)]
                               ^ (64'd1 << $urandom_range(0, gf2rs_pkg::ROW_W - 1));
                4:
                    if (prev.size() > 1)
                        bits = prev[$urandom_range(0, prev.size() - 1)]
                               ^ prev[$urandom_range(0, prev.size() - 1)];
                5:
                    bits = $urandom_range(0, 1) ? '1 : '0;
                6:
                    if (prev.size() > 0)
                        bits = prev[$urandom_range(0, prev.size() - 1)];
                7:
                    bits = bits & 64'h0000_0000_0000_ffff;
                default:
                    ;
            endcase
            prev.push_back(bits);
            send_row(bits, r + 1 == rows);
        end
    endtask

    // Drop valid, then hold until every queued output row has been seen
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (sparse_rows_q.size() == 0);
    endtask

    task automatic write_columns(input logic [gf2rs_pkg::CCOUNT_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        col_count = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Reset value of column_count, single-row matrix
    task automatic test_reset_columns();
        send_row('1, 1'b1);
    endtask

    task automatic test_row_extremes();
        send_row('0, 1'b0);
        send_row('1, 1'b0);
        send_row('1, 1'b0);
        send_row(64'h8000_0000_0000_0001, 1'b0);
        send_row(64'haaaa_aaaa_aaaa_aaaa, 1'b1);
    endtask

    // Zero columns, one column, one short of full width, above-range and full width
    task automatic test_column_limits();
        logic [gf2rs_pkg::CCOUNT_W-1:0] limits [5];
        int unsigned                    j;
        limits = '{7'd0, 7'd1, 7'd63, 7'd127, 7'd64};
        for (j = 0; j < 5; j++)
        begin
            write_columns(limits[j]);
            send_row('1, 1'b0);
            send_row({$urandom, $urandom}, 1'b1);
        end
    endtask

    task automatic test_deep_passes();
        send_matrix(9);
    endtask

    // Hold the output off long enough to back up the input, then pause the sender
    task automatic test_output_backpressure();
        wait_drained();
        rx_hold_len = LONG_HOLD;
        repeat (3) send_matrix(3);
        wait_drained();
        send_matrix(4);
    endtask

    task automatic test_random_matrices(input int unsigned n_rows, input bit with_idling);
        int unsigned                    sent;
        int unsigned                    size;
        int unsigned                    pick;
        logic [gf2rs_pkg::CCOUNT_W-1:0] cc;
        tx_gaps_on  = with_idling;
        rx_stall_on = with_idling;
        sent = 0;
        while (sent < n_rows)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                cc = '0;
            else if (pick < 3)
                cc = $urandom_range(65, 127);
            else
                cc = $urandom_range(1, 64);
            // Skip the drain and write between blocks once idling is off
            if (with_idling || sent == 0)
            begin
                write_columns(cc);
            end
            repeat ($urandom_range(2, 4))
            begin
                size = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 8)
                                                   : $urandom_range(1, 6);
                send_matrix(size);
                sent += size;
            end
        end
    endtask

    // Receiver: random stall bursts, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold_len > 0)
            begin
                out_ready <= 1'b0;
                repeat (rx_hold_len) @(negedge clk);
                rx_hold_len = 0;
                out_ready <= 1'b1;
            end
            else if (rx_stall_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (sparse_rows_q.size() == 0)
            begin
                $error("unexpected output row: row_index %0d, out_row_bits %h",
                       out_data.row_index, out_data.out_row_bits);
                fail_count++;
            end
            else
            begin
                next_want = sparse_rows_q.pop_front();
                if (out_data.out_row_bits !== next_want.out_row_bits)
                begin
                    $error("out_row_bits: expected %h, got %h",
                           next_want.out_row_bits, out_data.out_row_bits);
                    fail_count++;
                end
                if (out_data.row_index !== next_want.row_index)
                begin
                    $error("row_index: expected %0d, got %0d",
                           next_want.row_index, out_data.row_index);
                    fail_count++;
                end
                if (out_data.ones_removed !== next_want.ones_removed)
                begin
                    $error("ones_removed: expected %0d, got %0d",
                           next_want.ones_removed, out_data.ones_removed);
                    fail_count++;
                end
                if (out_data.last_out !== next_want.last_out)
                begin
                    $error("last_out: expected %0d, got %0d",
                           next_want.last_out, out_data.last_out);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("gf2_row_sparsifier: mismatch");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_columns();
        test_row_extremes();
        test_column_limits();
        test_deep_passes();
        test_output_backpressure();
        test_random_matrices(100, 1'b1);
        test_random_matrices(30, 1'b0);

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && sparse_rows_q.size() == 0)
            $display("gf2_row_sparsifier: match");
        else
            $display("gf2_row_sparsifier: mismatch");
        $finish;
    end

endmodule
